@@ rtl/core/triangle_face_normal_core_macros.svh @@
// ---------------------------------------------------------------------------
// triangle_face_normal_core_macros
// Assertion helpers for the triangle face normal core. Define ASSERT_OFF to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFN_ASSERT_IMP(lbl, ante, cons, msg)
`define TFN_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/tfn_pkg.sv @@
// ---------------------------------------------------------------------------
// tfn_pkg
// Types and constants shared by the triangle face normal core.
// ---------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int DL_W     = 15;
    localparam int M_W      = 30;
    localparam int RAD_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int Q_W      = 15;
    localparam int SQ_LAT   = ROOT_W;
    localparam int DIV_LAT  = Q_W;
    localparam int NORM_SH  = 14;

    localparam logic [DL_W-1:0] DL_RESET = 15'd410;
    localparam logic [17:0]     RECIP3   = 18'd174763;

    typedef struct packed {
        logic signed [15:0] v0_x;
        logic signed [15:0] v0_y;
        logic signed [15:0] v0_z;
        logic signed [15:0] v1_x;
        logic signed [15:0] v1_y;
        logic signed [15:0] v1_z;
        logic signed [15:0] v2_x;
        logic signed [15:0] v2_y;
        logic signed [15:0] v2_z;
    } tri_t;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] cen_x;
        logic signed [15:0] cen_y;
        logic signed [15:0] cen_z;
        logic signed [15:0] tip_x;
        logic signed [15:0] tip_y;
        logic signed [15:0] tip_z;
        logic               degenerate;
    } res_t;

    typedef struct packed {
        logic signed [16:0] a_x;
        logic signed [16:0] a_y;
        logic signed [16:0] a_z;
        logic signed [16:0] b_x;
        logic signed [16:0] b_y;
        logic signed [16:0] b_z;
        logic signed [17:0] s_x;
        logic signed [17:0] s_y;
        logic signed [17:0] s_z;
    } edge_t;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][15:0] cen;
        logic             degen;
    } side_t;

endpackage

`default_nettype wire

@@ rtl/core/tfn_front.sv @@
// ---------------------------------------------------------------------------
// tfn_front
// Input stage: takes a triangle beat, forms both edges from the first vertex and the vertex sums.
// ---------------------------------------------------------------------------
`default_nettype none

module tfn_front
    import tfn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  tri_valid,
    output logic       tri_stall,
    input  wire tri_t  tri_data,
    output logic       push,
    output edge_t      push_data,
    input  wire logic  full
);

    logic  fr_valid_reg;
    logic  fr_valid_next;
    edge_t fr_data_reg;
    edge_t fr_data_next;

    assign push      = fr_valid_reg && !full;
    assign tri_stall = fr_valid_reg && full;
    assign push_data = fr_data_reg;

    always_comb
    begin
        fr_valid_next      = tri_stall ? fr_valid_reg : tri_valid;
        fr_data_next.a_x   = 17'(tri_data.v1_x) - 17'(tri_data.v0_x);
        fr_data_next.a_y   = 17'(tri_data.v1_y) - 17'(tri_data.v0_y);
        fr_data_next.a_z   = 17'(tri_data.v1_z) - 17'(tri_data.v0_z);
        fr_data_next.b_x   = 17'(tri_data.v2_x) - 17'(tri_data.v0_x);
        fr_data_next.b_y   = 17'(tri_data.v2_y) - 17'(tri_data.v0_y);
        fr_data_next.b_z   = 17'(tri_data.v2_z) - 17'(tri_data.v0_z);
        fr_data_next.s_x   = 18'(tri_data.v0_x) + 18'(tri_data.v1_x) + 18'(tri_data.v2_x);
        fr_data_next.s_y   = 18'(tri_data.v0_y) + 18'(tri_data.v1_y) + 18'(tri_data.v2_y);
        fr_data_next.s_z   = 18'(tri_data.v0_z) + 18'(tri_data.v1_z) + 18'(tri_data.v2_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!tri_stall && tri_valid)
        begin
            fr_data_reg <= fr_data_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfn_queue.sv @@
// ---------------------------------------------------------------------------
// tfn_queue
// Small FIFO between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module tfn_queue
    import tfn_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire edge_t push_data,
    output logic       full,
    input  wire logic  pop,
    output edge_t      pop_data,
    output logic       not_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    edge_t            mem [DEPTH];
    logic [IDX_W-1:0] wr_reg;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] rd_reg;
    logic [IDX_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfn_isqrt.sv @@
// ---------------------------------------------------------------------------
// tfn_isqrt
// Pipelined floor square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tfn_isqrt
    import tfn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [RAD_W-1:0]  rad,
    output logic      [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  x_reg   [SQ_LAT];
    logic [ROOT_W+1:0] rem_reg [SQ_LAT];
    logic [ROOT_W-1:0] r_reg   [SQ_LAT];

    for (genvar k = 0; k < SQ_LAT; k++)
    begin : g_stage
        logic [RAD_W-1:0]  x_in;
        logic [ROOT_W+1:0] rem_in;
        logic [ROOT_W-1:0] r_in;
        logic [ROOT_W+3:0] acc;
        logic [ROOT_W+3:0] trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign x_in   = rad;
            assign rem_in = '0;
            assign r_in   = '0;
        end
        else
        begin : g_rest
            assign x_in   = x_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign r_in   = r_reg[k-1];
        end

        assign acc   = {rem_in, x_in[RAD_W-1 -: 2]};
        assign trial = {2'b00, r_in, 2'b01};
        assign ge    = (acc >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_in << 2;
                rem_reg[k] <= ge ? (ROOT_W+2)'(acc - trial) : (ROOT_W+2)'(acc);
                r_reg[k]   <= {r_in[ROOT_W-2:0], ge};
            end
        end
    end

    assign root = r_reg[SQ_LAT-1];

endmodule

`default_nettype wire

@@ rtl/core/tfn_div.sv @@
// ---------------------------------------------------------------------------
// tfn_div
// Pipelined rounded divide m * 2^14 / len, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tfn_div
    import tfn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [M_W-1:0]    m,
    input  wire logic [ROOT_W-1:0] len,
    output logic      [Q_W-1:0]    q
);

    localparam int NUM_W = M_W + NORM_SH + 1;

    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] r_reg   [DIV_LAT];
    logic [Q_W-1:0]    lo_reg  [DIV_LAT];
    logic [Q_W-1:0]    q_reg   [DIV_LAT];
    logic [ROOT_W-1:0] len_reg [DIV_LAT];

    assign num = {1'b0, m, NORM_SH'(0)} + NUM_W'(len >> 1);

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_stage
        logic [ROOT_W-1:0] r_in;
        logic [Q_W-1:0]    lo_in;
        logic [Q_W-1:0]    q_in;
        logic [ROOT_W-1:0] len_in;
        logic [ROOT_W:0]   sh;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign r_in   = ROOT_W'(num[NUM_W-1:Q_W]);
            assign lo_in  = num[Q_W-1:0];
            assign q_in   = '0;
            assign len_in = len;
        end
        else
        begin : g_rest
            assign r_in   = r_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign len_in = len_reg[k-1];
        end

        assign sh = {r_in, lo_in[Q_W-1]};
        assign ge = (sh >= {1'b0, len_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= ge ? ROOT_W'(sh - {1'b0, len_in}) : ROOT_W'(sh);
                lo_reg[k]  <= lo_in << 1;
                q_reg[k]   <= {q_in[Q_W-2:0], ge};
                len_reg[k] <= len_in;
            end
        end
    end

    assign q = q_reg[DIV_LAT-1];

endmodule

`default_nettype wire

@@ rtl/core/tfn_back.sv @@
// ---------------------------------------------------------------------------
// tfn_back
// Execution pipeline: cross product, scaling, length, normalize, centroid
// and tip. The whole pipe advances together when the output can move.
// ---------------------------------------------------------------------------
`default_nettype none
`include "triangle_face_normal_core_macros.svh"

module tfn_back
    import tfn_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire edge_t           q_data,
    output logic                 pop,
    input  wire logic [DL_W-1:0] debug_length,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output res_t                 res_data
);

    localparam int TAIL = SQ_LAT + DIV_LAT;

    logic en;

    logic [6:0]       v_reg;
    logic [TAIL-1:0]  vdl_reg;
    logic             v8_reg;
    logic             res_valid_reg;

    logic signed [33:0] p_reg  [6];
    logic signed [33:0] p_next [6];
    logic [34:0]        cm_reg  [3];
    logic [34:0]        cm_next [3];
    logic [2:0]         sn_reg;
    logic [2:0]         sn_next;

    logic [2:0][33:0]   m2_reg, m2_next;
    side_t              side2_reg, side2_next;

    logic [2:0][33:0]   m3_reg;
    logic [33:0]        big3_reg, big3_next;
    side_t              side3_reg;

    logic [2:0][33:0]   m4_reg;
    logic               shl4_reg, shl4_next;
    logic [4:0]         amt4_reg, amt4_next;
    logic [5:0]         pos;
    side_t              side4_reg;

    logic [2:0][M_W-1:0] m5_reg, m5_next;
    side_t              side5_reg;

    logic [2:0][2*M_W-1:0] sq6_reg, sq6_next;
    logic [2:0][M_W-1:0] m6_reg;
    side_t              side6_reg;

    logic [RAD_W-1:0]   ss7_reg;
    logic [2:0][M_W-1:0] m7_reg;
    side_t              side7_reg;

    logic [2:0][M_W-1:0] mdl_reg [SQ_LAT];
    side_t              sdl_reg [TAIL];

    logic [ROOT_W-1:0]  len;
    logic [2:0][Q_W-1:0] qd;

    logic [2:0][2*Q_W-1:0] prod8_reg, prod8_next;
    logic [2:0][Q_W-1:0] q8_reg;
    side_t              side8_reg;

    logic [2:0][15:0]   nrm;
    logic [2:0][15:0]   tip;
    res_t               res_reg, res_next;

    assign en        = !res_valid_reg || !res_stall;
    assign pop       = en && q_valid;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // stage 1: partial products of the cross product, centroid reciprocal
    always_comb
    begin
        logic signed [17:0] s [3];
        logic [16:0] sabs;
        s[0] = q_data.s_x;
        s[1] = q_data.s_y;
        s[2] = q_data.s_z;
        p_next[0] = 34'(q_data.a_y) * 34'(q_data.b_z);
        p_next[1] = 34'(q_data.a_z) * 34'(q_data.b_y);
        p_next[2] = 34'(q_data.a_z) * 34'(q_data.b_x);
        p_next[3] = 34'(q_data.a_x) * 34'(q_data.b_z);
        p_next[4] = 34'(q_data.a_x) * 34'(q_data.b_y);
        p_next[5] = 34'(q_data.a_y) * 34'(q_data.b_x);
        for (int j = 0; j < 3; j++)
        begin
            sabs       = s[j][17] ? 17'(-s[j]) : 17'(s[j]);
            sn_next[j] = s[j][17];
            cm_next[j] = 35'(sabs + 17'd1) * 35'(RECIP3);
        end
    end

    // stage 2: cross product, magnitudes, centroid
    always_comb
    begin
        logic signed [34:0] c;
        logic [15:0] cq;
        side2_next.degen = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            c = 35'(p_reg[2*j]) - 35'(p_reg[2*j+1]);
            side2_next.neg[j] = c[34];
            m2_next[j] = c[34] ? 34'(-c) : c[33:0];
            if (c != '0)
            begin
                side2_next.degen = 1'b0;
            end
            cq = cm_reg[j][34:19];
            side2_next.cen[j] = sn_reg[j] ? 16'(-cq) : cq;
        end
    end

    // stage 3: largest magnitude
    always_comb
    begin
        big3_next = m2_reg[0];
        if (m2_reg[1] > big3_next)
        begin
            big3_next = m2_reg[1];
        end
        if (m2_reg[2] > big3_next)
        begin
            big3_next = m2_reg[2];
        end
    end

    // stage 4: shift that brings the largest into [2^29, 2^30)
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < 34; i++)
        begin
            if (big3_reg[i])
            begin
                pos = 6'(i);
            end
        end
        shl4_next = (pos < 6'd30);
        amt4_next = shl4_next ? 5'(6'd29 - pos) : 5'(pos - 6'd29);
    end

    // stage 5: apply shift
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            m5_next[j] = shl4_reg ? M_W'(m4_reg[j] << amt4_reg)
                                  : M_W'(m4_reg[j] >> amt4_reg);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq6_next[j] = (2*M_W)'(m5_reg[j]) * (2*M_W)'(m5_reg[j]);
        end
    end

    tfn_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (ss7_reg),
        .root (len)
    );

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        tfn_div u_div
        (
            .clk (clk),
            .en  (en),
            .m   (mdl_reg[SQ_LAT-1][j]),
            .len (len),
            .q   (qd[j])
        );
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod8_next[j] = (2*Q_W)'(qd[j]) * (2*Q_W)'(debug_length);
        end
    end

    // final stage: sign, rounded offset, saturating add
    always_comb
    begin
        logic [15:0] off;
        logic signed [17:0] cw;
        logic signed [17:0] ow;
        logic signed [17:0] tw;
        for (int j = 0; j < 3; j++)
        begin
            off = 16'((31'(prod8_reg[j]) + 31'd8192) >> NORM_SH);
            cw  = {{2{side8_reg.cen[j][15]}}, side8_reg.cen[j]};
            ow  = {2'b00, off};
            tw  = side8_reg.neg[j] ? cw - ow : cw + ow;
            if (side8_reg.degen)
            begin
                nrm[j] = '0;
                tip[j] = side8_reg.cen[j];
            end
            else
            begin
                nrm[j] = side8_reg.neg[j] ? 16'(-{1'b0, q8_reg[j]}) : {1'b0, q8_reg[j]};
                if (tw > 18'sd32767)
                begin
                    tip[j] = 16'h7fff;
                end
                else if (tw < -18'sd32768)
                begin
                    tip[j] = 16'h8000;
                end
                else
                begin
                    tip[j] = tw[15:0];
                end
            end
        end
        res_next.norm_x     = nrm[0];
        res_next.norm_y     = nrm[1];
        res_next.norm_z     = nrm[2];
        res_next.cen_x      = side8_reg.cen[0];
        res_next.cen_y      = side8_reg.cen[1];
        res_next.cen_z      = side8_reg.cen[2];
        res_next.tip_x      = tip[0];
        res_next.tip_y      = tip[1];
        res_next.tip_z      = tip[2];
        res_next.degenerate = side8_reg.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            vdl_reg       <= '0;
            v8_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[5:0], q_valid};
            vdl_reg       <= {vdl_reg[TAIL-2:0], v_reg[6]};
            v8_reg        <= vdl_reg[TAIL-1];
            res_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            cm_reg    <= cm_next;
            sn_reg    <= sn_next;
            m2_reg    <= m2_next;
            side2_reg <= side2_next;
            m3_reg    <= m2_reg;
            big3_reg  <= big3_next;
            side3_reg <= side2_reg;
            m4_reg    <= m3_reg;
            shl4_reg  <= shl4_next;
            amt4_reg  <= amt4_next;
            side4_reg <= side3_reg;
            m5_reg    <= m5_next;
            side5_reg <= side4_reg;
            sq6_reg   <= sq6_next;
            m6_reg    <= m5_reg;
            side6_reg <= side5_reg;
            ss7_reg   <= RAD_W'(sq6_reg[0]) + RAD_W'(sq6_reg[1]) + RAD_W'(sq6_reg[2]);
            m7_reg    <= m6_reg;
            side7_reg <= side6_reg;
            mdl_reg[0] <= m7_reg;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                mdl_reg[i] <= mdl_reg[i-1];
            end
            sdl_reg[0] <= side7_reg;
            for (int i = 1; i < TAIL; i++)
            begin
                sdl_reg[i] <= sdl_reg[i-1];
            end
            prod8_reg <= prod8_next;
            q8_reg    <= qd;
            side8_reg <= sdl_reg[TAIL-1];
            res_reg   <= res_next;
        end
    end

    `TFN_ASSERT_IMP(a_degen_norm, res_valid && res_data.degenerate,
        res_data.norm_x == 16'sd0 && res_data.norm_y == 16'sd0 && res_data.norm_z == 16'sd0,
        "degenerate beat with nonzero normal")
    `TFN_ASSERT_IMP(a_degen_tip, res_valid && res_data.degenerate,
        res_data.tip_x == res_data.cen_x && res_data.tip_y == res_data.cen_y &&
        res_data.tip_z == res_data.cen_z,
        "degenerate beat with tip off the centroid")
    `TFN_ASSERT_IMP(a_norm_range, res_valid && !res_data.degenerate,
        res_data.norm_x <= 16'sd16384 && res_data.norm_x >= -16'sd16384 &&
        res_data.norm_y <= 16'sd16384 && res_data.norm_y >= -16'sd16384 &&
        res_data.norm_z <= 16'sd16384 && res_data.norm_z >= -16'sd16384,
        "normal component out of unit range")
    `TFN_ASSERT_IMP(a_no_pop, res_valid && res_stall, !pop,
        "pipe moved while output stalled")
    `TFN_ASSERT_NXT(a_hold, res_valid && res_stall, res_valid && $stable(res_data),
        "stalled result beat changed")

endmodule

`default_nettype wire

@@ rtl/core/triangle_face_normal_core.sv @@
// ---------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal, centroid and debug tip of a triangle.
// ---------------------------------------------------------------------------
// Throughput: one triangle per cycle while the output is not stalled; the square root
//   and divide are fully pipelined, one bit per stage (31 and 15 stages).
// A stalled output freezes the back pipe; the queue then lets the front keep
//   taking beats until it fills.
// Reset: asynchronous, clears all valid state and sets debug_length to 410.
`default_nettype none

module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tri_valid,
    output logic                 tri_stall,
    input  wire tri_t            tri_data,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output res_t                 res_data,
    input  wire logic            cfg_we,
    input  wire logic [DL_W-1:0] cfg_data
);

    logic [DL_W-1:0] dl_reg;
    logic            push;
    edge_t           push_data;
    logic            full;
    logic            pop;
    edge_t           pop_data;
    logic            not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg <= DL_RESET;
        end
        else if (cfg_we)
        begin
            dl_reg <= cfg_data;
        end
    end

    tfn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_data  (tri_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    tfn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    tfn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (not_empty),
        .q_data       (pop_data),
        .pop          (pop),
        .debug_length (dl_reg),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_data     (res_data)
    );

endmodule

`default_nettype wire

@@ test/triangle_face_normal_checker.sv @@
// ---------------------------------------------------------------------------
// triangle_face_normal_checker
// Watches the triangle and result channels, predicts the face normal,
// centroid, tip point and degenerate flag of each accepted triangle, and
// compares every result beat against it as a whole record, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module triangle_face_normal_checker
    import tfn_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tri_valid,
    input  wire logic            tri_stall,
    input  wire tri_t            tri_data,
    input  wire logic            res_valid,
    input  wire logic            res_stall,
    input  wire res_t            res_data,
    input  wire logic            cfg_we,
    input  wire logic [DL_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending
);

    logic [DL_W-1:0] seg_len;
    res_t            expected_faces[$];

    function automatic logic signed [15:0] centroid_of(longint s);
        longint m;
        m = (s < 0) ? -s : s;
        m = (m + 1) / 3;
        return (s < 0) ? -m : m;
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic res_t face_of(tri_t t, logic [DL_W-1:0] dl);
        longint p[3][3];
        longint a[3], b[3], c[3], cen[3];
        longint unsigned m[3], big, ss, len, q, off;
        longint tp;
        res_t r;
        p[0] = '{t.v0_x, t.v0_y, t.v0_z};
        p[1] = '{t.v1_x, t.v1_y, t.v1_z};
        p[2] = '{t.v2_x, t.v2_y, t.v2_z};
        for (int j = 0; j < 3; j++)
        begin
            a[j] = p[1][j] - p[0][j];
            b[j] = p[2][j] - p[0][j];
            cen[j] = centroid_of(p[0][j] + p[1][j] + p[2][j]);
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        r.cen_x = cen[0];
        r.cen_y = cen[1];
        r.cen_z = cen[2];
        r.degenerate = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        if (r.degenerate)
        begin
            {r.norm_x, r.norm_y, r.norm_z} = '0;
            r.tip_x = cen[0];
            r.tip_y = cen[1];
            r.tip_z = cen[2];
            return r;
        end
        for (int j = 0; j < 3; j++)
            m[j] = (c[j] < 0) ? -c[j] : c[j];
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        while (big >= (64'd1 << 30))
        begin
            big >>= 1;
            for (int j = 0; j < 3; j++) m[j] >>= 1;
        end
        while (big < (64'd1 << 29))
        begin
            big <<= 1;
            for (int j = 0; j < 3; j++) m[j] <<= 1;
        end
        ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(ss);
        for (int j = 0; j < 3; j++)
        begin
            q = (m[j] * 16384 + (len >> 1)) / len;
            off = (q * dl + 8192) >> 14;
            tp = (c[j] < 0) ? cen[j] - longint'(off) : cen[j] + longint'(off);
            if (tp > 32767) tp = 32767;
            if (tp < -32768) tp = -32768;
            if (c[j] < 0) q = -q;
            case (j)
                0: begin r.norm_x = q; r.tip_x = tp; end
                1: begin r.norm_y = q; r.tip_y = tp; end
                default: begin r.norm_z = q; r.tip_z = tp; end
            endcase
        end
        return r;
    endfunction

    assign pending = expected_faces.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            seg_len <= DL_RESET;
            fail_count <= 0;
            expected_faces.delete();
        end
        else
        begin
            if (cfg_we)
                seg_len <= cfg_data;
            if (tri_valid && !tri_stall)
                expected_faces.insert(expected_faces.size(), face_of(tri_data, seg_len));
            if (res_valid && !res_stall)
            begin
                if (expected_faces.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, res_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_faces.pop_front();
                    if (want !== res_data)
                    begin
                        $display("%0t: expected %h actual %h", $time, want, res_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ test/triangle_face_normal_core_tb.sv @@
// ---------------------------------------------------------------------------
// triangle_face_normal_core_tb
// Drives directed and random triangles with random gaps and output stalls
// over several debug segment lengths; the checker does the comparison.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module triangle_face_normal_core_tb;
    import tfn_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            tri_valid;
    logic            tri_stall;
    tri_t            tri_data;
    logic            res_valid;
    logic            res_stall;
    res_t            res_data;
    logic            cfg_we;
    logic [DL_W-1:0] cfg_data;
    int              fail_count;
    int              pending;
    bit              hold_req;

    triangle_face_normal_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    triangle_face_normal_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        res_stall = 1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1;
                repeat (200) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (n > 0)
                begin
                    res_stall <= 1;
                    repeat (n) @(posedge clk);
                end
            end
            res_stall <= 0;
            @(posedge clk);
        end
    end

    function automatic logic signed [15:0] coord(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
        endcase
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int k;
        k = $urandom_range(0, 3);
        t = {coord(k), coord(k), coord(k), coord(k), coord(k),
             coord(k), coord(k), coord(k), coord(k)};
        case ($urandom_range(0, 9))
            0: t[95:48] = t[143:96];
            1: t[47:0] = t[95:48];
            2:
            begin
                t.v2_x = t.v1_x;
                t.v2_y = t.v1_y;
                t.v2_z = t.v1_z;
                t.v1_x = t.v0_x;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic send(tri_t t, bit no_gap);
        int n;
        n = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
        if (n > 0)
        begin
            tri_valid <= 0;
            repeat (n) @(posedge clk);
        end
        tri_valid <= 1;
        tri_data <= t;
        @(posedge clk);
        while (tri_stall)
            @(posedge clk);
    endtask

    task automatic drain_and_set(logic [DL_W-1:0] v);
        tri_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    initial
    begin
        logic [DL_W-1:0] lens[5];
        tri_t t;
        int wait_n;
        lens = '{15'd0, 15'h7fff, 15'd4096, 15'd1, 15'd410};
        rst_n = 0;
        tri_valid = 0;
        tri_data = '0;
        cfg_we = 0;
        cfg_data = '0;
        hold_req = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, unit triangles, degenerate cases
        send('0, 0);
        send({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh7fff}, 0);
        send({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh8000}, 0);
        send({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh8000, 16'sh7fff}, 0);
        send({48'h0, 16'sd4096, 32'h0, 16'sh0, 16'sd4096, 16'sh0}, 0);
        send({48'h0, 16'sh0, 16'sd4096, 16'sh0, 16'sd4096, 32'h0}, 0);
        send({48'h0, 16'sh0, 16'sd1, 16'sh0, 16'sh0, 16'sh0, 16'sd1}, 0);
        send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5}, 0);
        send({48'h0, 16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd2}, 0);
        send({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7ffe}, 0);
        send({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8001, 16'sh8000}, 0);
        send(16'sd1 << 128 | 144'hffff_ffff_ffff_0001_0002_0003_fffe_0000_0001, 0);

        foreach (lens[i])
        begin
            drain_and_set(lens[i]);
            if (i == 2)
            begin
                // more beats than the pipe and queue can hold
                hold_req = 1;
                for (int j = 0; j < 80; j++)
                    send(random_tri(), 1);
            end
            for (int j = 0; j < 370; j++)
            begin
                t = random_tri();
                if (lens[i] == 15'h7fff && j < 20)
                    t = {16'sh7ff0, 16'sh7ff0, 16'sh7ff0, 16'sh7000, 16'sh7ff0,
                         16'sh7ff0, 16'sh7ff0, 16'sh7000, 16'sh7ff0} ^ (j & 15);
                send(t, 0);
            end
        end

        tri_valid <= 0;
        @(posedge clk);
        wait_n = 0;
        while (pending != 0 && wait_n < 100000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tfn_pkg.sv
rtl/core/tfn_front.sv
rtl/core/tfn_queue.sv
rtl/core/tfn_isqrt.sv
rtl/core/tfn_div.sv
rtl/core/tfn_back.sv
rtl/core/triangle_face_normal_core.sv
test/triangle_face_normal_checker.sv
test/triangle_face_normal_core_tb.sv
